// ===== sv/dtl_pkg.sv =====
// dtl_pkg: shared types, character constants, register indexes and the
// lexer state functions of the delimited text token lexer.
// No dependencies.
`default_nettype none

package dtl_pkg;

  localparam int LINE_BITS_DEF   = 20;
  localparam int COLUMN_BITS_DEF = 16;
  localparam int QUEUE_DEPTH     = 4;
  localparam int CFG_IDX_BITS    = 3;
  localparam int CFG_DATA_BITS   = 8;

  // configuration register indexes
  localparam logic [CFG_IDX_BITS-1:0] REG_COMMENT  = 3'd0;
  localparam logic [CFG_IDX_BITS-1:0] REG_STMT_SEP = 3'd1;
  localparam logic [CFG_IDX_BITS-1:0] REG_TERM     = 3'd2;
  localparam logic [CFG_IDX_BITS-1:0] REG_VALUE    = 3'd3;
  localparam logic [CFG_IDX_BITS-1:0] REG_TUPLE    = 3'd4;
  localparam logic [CFG_IDX_BITS-1:0] REG_STR      = 3'd5;

  localparam logic [7:0] RST_COMMENT  = 8'd35;
  localparam logic [7:0] RST_STMT_SEP = 8'd44;
  localparam logic [7:0] RST_TERM     = 8'd59;
  localparam logic [7:0] RST_VALUE    = 8'd61;
  localparam logic [7:0] RST_TUPLE    = 8'd47;
  localparam logic [7:0] RST_STR      = 8'd124;

  localparam logic [7:0] CHAR_TAB     = 8'd9;
  localparam logic [7:0] CHAR_LF      = 8'd10;
  localparam logic [7:0] CHAR_CR      = 8'd13;
  localparam logic [7:0] CHAR_SPACE   = 8'd32;
  localparam logic [7:0] CHAR_MINUS   = 8'd45;
  localparam logic [7:0] CHAR_ZERO    = 8'd48;
  localparam logic [7:0] CHAR_NINE    = 8'd57;
  localparam logic [7:0] CHAR_UPPER_A = 8'd65;
  localparam logic [7:0] CHAR_UPPER_Z = 8'd90;
  localparam logic [7:0] CHAR_USCORE  = 8'd95;
  localparam logic [7:0] CHAR_LOWER_A = 8'd97;
  localparam logic [7:0] CHAR_LOWER_Z = 8'd122;

  localparam logic [2:0] KIND_INVALID = 3'd0;
  localparam logic [2:0] KIND_WORD    = 3'd1;
  localparam logic [2:0] KIND_NUMBER  = 3'd2;
  localparam logic [2:0] KIND_STRING  = 3'd3;
  localparam logic [2:0] KIND_VALUE   = 3'd4;
  localparam logic [2:0] KIND_TUPLE   = 3'd5;
  localparam logic [2:0] KIND_SSEP    = 3'd6;
  localparam logic [2:0] KIND_TERM    = 3'd7;

  localparam logic [1:0] EOF_NONE  = 2'd0;
  localparam logic [1:0] EOF_CLEAN = 2'd1;
  localparam logic [1:0] EOF_OPEN  = 2'd2;

  typedef enum logic [11:0] {
    ST_SCAN      = 12'b0000_0000_0001,
    ST_INVALID   = 12'b0000_0000_0010,
    ST_COMMENT   = 12'b0000_0000_0100,
    ST_WORD      = 12'b0000_0000_1000,
    ST_NUMBER    = 12'b0000_0001_0000,
    ST_STR_START = 12'b0000_0010_0000,
    ST_STR       = 12'b0000_0100_0000,
    ST_STR_END   = 12'b0000_1000_0000,
    ST_VALUE     = 12'b0001_0000_0000,
    ST_TUPLE     = 12'b0010_0000_0000,
    ST_SSEP      = 12'b0100_0000_0000,
    ST_TERM      = 12'b1000_0000_0000
  } lex_state_t;

  typedef struct packed {
    logic [7:0] comment_char;
    logic [7:0] statement_sep_char;
    logic [7:0] terminator_char;
    logic [7:0] value_sep_char;
    logic [7:0] tuple_sep_char;
    logic [7:0] string_delim_char;
  } cfg_t;

  // result word without the position fields
  typedef struct packed {
    logic [7:0] char_out;
    logic       has_char;
    logic [2:0] token_kind;
    logic       token_end;
    logic [1:0] eof_status;
    logic       last_result;
  } res_base_t;

  typedef struct packed {
    logic push0;
    logic push1;
  } q_push_t;

  typedef struct packed {
    logic room;
    logic nonempty;
  } q_stat_t;

  function automatic lex_state_t state_after(lex_state_t cur, logic [7:0] c, cfg_t cfg);
    logic is_nl;
    logic is_ws;
    logic is_alpha;
    logic is_digit;
    lex_state_t r;
    is_nl    = (c == CHAR_LF) || (c == CHAR_CR);
    is_ws    = is_nl || (c == CHAR_SPACE) || (c == CHAR_TAB);
    is_alpha = ((c >= CHAR_UPPER_A) && (c <= CHAR_UPPER_Z)) ||
               ((c >= CHAR_LOWER_A) && (c <= CHAR_LOWER_Z)) || (c == CHAR_USCORE);
    is_digit = ((c >= CHAR_ZERO) && (c <= CHAR_NINE)) ||
               ((c == CHAR_MINUS) && (cur != ST_NUMBER) && (cur != ST_WORD));
    if ((cur == ST_STR_START) || (cur == ST_STR)) begin
      r = ((c == cfg.string_delim_char) || is_nl) ? ST_STR_END : ST_STR;
    end else if (((cur == ST_COMMENT) && !is_nl) || (c == cfg.comment_char)) begin
      r = ST_COMMENT;
    end else if (is_ws) begin
      r = ST_SCAN;
    end else if (is_alpha) begin
      r = ST_WORD;
    end else if (is_digit) begin
      r = ST_NUMBER;
    end else if (c == cfg.value_sep_char) begin
      r = ST_VALUE;
    end else if (c == cfg.tuple_sep_char) begin
      r = ST_TUPLE;
    end else if (c == cfg.statement_sep_char) begin
      r = ST_SSEP;
    end else if (c == cfg.terminator_char) begin
      r = ST_TERM;
    end else if (c == cfg.string_delim_char) begin
      r = ST_STR_START;
    end else begin
      r = ST_INVALID;
    end
    return r;
  endfunction

  function automatic logic is_recorded(lex_state_t s);
    logic r;
    case (s)
      ST_INVALID, ST_WORD, ST_NUMBER, ST_STR,
      ST_VALUE, ST_TUPLE, ST_SSEP, ST_TERM: r = 1'b1;
      default: r = 1'b0;
    endcase
    return r;
  endfunction

  function automatic logic is_complete(lex_state_t cur, lex_state_t nxt);
    logic r;
    case (cur)
      ST_WORD, ST_NUMBER, ST_STR_END: r = (cur != nxt);
      ST_INVALID, ST_VALUE, ST_TUPLE, ST_SSEP, ST_TERM: r = 1'b1;
      default: r = 1'b0;
    endcase
    return r;
  endfunction

  function automatic logic has_kind(lex_state_t s);
    return (s != ST_SCAN) && (s != ST_COMMENT);
  endfunction

  function automatic logic [2:0] kind_of(lex_state_t s);
    logic [2:0] r;
    case (s)
      ST_WORD:                         r = KIND_WORD;
      ST_NUMBER:                       r = KIND_NUMBER;
      ST_STR_START, ST_STR, ST_STR_END: r = KIND_STRING;
      ST_VALUE:                        r = KIND_VALUE;
      ST_TUPLE:                        r = KIND_TUPLE;
      ST_SSEP:                         r = KIND_SSEP;
      ST_TERM:                         r = KIND_TERM;
      default:                         r = KIND_INVALID;
    endcase
    return r;
  endfunction

endpackage

`default_nettype wire

// ===== sv/dtl_if.sv =====
// dtl_in_if / dtl_out_if: valid-ready channels for text words and results.
// Depends on dtl_pkg.
`default_nettype none

interface dtl_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_byte;
  logic       end_of_input;

  modport source (output valid, output in_byte, output end_of_input, input ready);
  modport sink   (input valid, input in_byte, input end_of_input, output ready);
endinterface

interface dtl_out_if #(
  parameter int LINE_BITS   = dtl_pkg::LINE_BITS_DEF,
  parameter int COLUMN_BITS = dtl_pkg::COLUMN_BITS_DEF
);
  logic                   valid;
  logic                   ready;
  logic [7:0]             char_out;
  logic                   has_char;
  logic [2:0]             token_kind;
  logic                   token_end;
  logic [1:0]             eof_status;
  logic [LINE_BITS-1:0]   token_line;
  logic [COLUMN_BITS-1:0] token_column;
  logic                   last_result;

  modport source (output valid, output char_out, output has_char, output token_kind,
                  output token_end, output eof_status, output token_line,
                  output token_column, output last_result, input ready);
  modport sink   (input valid, input char_out, input has_char, input token_kind,
                  input token_end, input eof_status, input token_line,
                  input token_column, input last_result, output ready);
endinterface

`default_nettype wire

// ===== sv/dtl_front.sv =====
// dtl_front: accepts text words, runs the lookahead lexer and position
// counters, and pushes up to two result words into the queue.
// Depends on dtl_pkg and dtl_if.
`default_nettype none

module dtl_front #(
  parameter int LINE_BITS   = dtl_pkg::LINE_BITS_DEF,
  parameter int COLUMN_BITS = dtl_pkg::COLUMN_BITS_DEF,
  parameter int ENTRY_W     = $bits(dtl_pkg::res_base_t) + LINE_BITS + COLUMN_BITS
) (
  input  wire logic         clk,
  input  wire logic         rst_n,
  input  wire dtl_pkg::cfg_t    cfg,
  dtl_in_if.sink            in_ch,
  input  wire dtl_pkg::q_stat_t q_stat,
  output dtl_pkg::q_push_t  q_push,
  output logic [ENTRY_W-1:0] q_data0,
  output logic [ENTRY_W-1:0] q_data1
);

  dtl_pkg::lex_state_t    lex_state_r, lex_state_nxt;
  logic [7:0]             pending_r, pending_nxt;
  logic                   have_pending_r, have_pending_nxt;
  logic                   token_open_r, token_open_nxt;
  logic [LINE_BITS-1:0]   line_r, line_nxt;
  logic [COLUMN_BITS-1:0] column_r, column_nxt;
  logic                   prev_cr_r, prev_cr_nxt;
  logic                   prev_lf_r, prev_lf_nxt;
  logic [LINE_BITS-1:0]   start_line_r, start_line_nxt;
  logic [COLUMN_BITS-1:0] start_column_r, start_column_nxt;

  logic                   acc, eoi, cr, lf;
  logic [7:0]             b, look;
  dtl_pkg::lex_state_t    cur, nxt;
  logic                   opening, rec, done, adv_emit, open_after;
  logic [LINE_BITS-1:0]   sl, line_b;
  logic [COLUMN_BITS-1:0] sc, col_b;
  dtl_pkg::res_base_t     base_a, base_b;

  assign in_ch.ready = q_stat.room;
  assign acc = in_ch.valid && q_stat.room;
  assign eoi = in_ch.end_of_input;
  assign b   = in_ch.in_byte;
  assign cr  = (b == dtl_pkg::CHAR_CR);
  assign lf  = (b == dtl_pkg::CHAR_LF);

  always_comb begin
    look       = eoi ? dtl_pkg::CHAR_LF : b;
    cur        = have_pending_r ? lex_state_r : dtl_pkg::ST_SCAN;
    opening    = have_pending_r && !token_open_r && dtl_pkg::has_kind(cur);
    sl         = opening ? line_r : start_line_r;
    sc         = opening ? column_r : start_column_r;
    nxt        = dtl_pkg::state_after(cur, look, cfg);
    rec        = dtl_pkg::is_recorded(cur);
    done       = dtl_pkg::is_complete(cur, nxt);
    adv_emit   = have_pending_r && (rec || done);
    open_after = (token_open_r || opening) && !(have_pending_r && done);

    base_a.char_out    = rec ? pending_r : 8'h00;
    base_a.has_char    = rec;
    base_a.token_kind  = dtl_pkg::kind_of(cur);
    base_a.token_end   = done;
    base_a.eof_status  = dtl_pkg::EOF_NONE;
    base_a.last_result = !eoi;

    base_b.char_out    = 8'h00;
    base_b.has_char    = 1'b0;
    base_b.token_kind  = dtl_pkg::KIND_INVALID;
    base_b.token_end   = 1'b0;
    base_b.eof_status  = open_after ? dtl_pkg::EOF_OPEN : dtl_pkg::EOF_CLEAN;
    base_b.last_result = 1'b1;
    line_b             = open_after ? sl : line_r;
    col_b              = open_after ? sc : column_r;

    q_push.push0 = acc && (adv_emit || eoi);
    q_push.push1 = acc && eoi && adv_emit;
    q_data0      = adv_emit ? {base_a, sl, sc} : {base_b, line_b, col_b};
    q_data1      = {base_b, line_b, col_b};
  end

  always_comb begin
    lex_state_nxt    = lex_state_r;
    pending_nxt      = pending_r;
    have_pending_nxt = have_pending_r;
    token_open_nxt   = token_open_r;
    line_nxt         = line_r;
    column_nxt       = column_r;
    prev_cr_nxt      = prev_cr_r;
    prev_lf_nxt      = prev_lf_r;
    start_line_nxt   = start_line_r;
    start_column_nxt = start_column_r;
    if (acc) begin
      if (eoi) begin
        lex_state_nxt    = dtl_pkg::ST_SCAN;
        have_pending_nxt = 1'b0;
        token_open_nxt   = 1'b0;
        line_nxt         = '0;
        column_nxt       = '0;
        prev_cr_nxt      = 1'b0;
        prev_lf_nxt      = 1'b0;
      end else begin
        lex_state_nxt    = nxt;
        pending_nxt      = b;
        have_pending_nxt = 1'b1;
        token_open_nxt   = open_after;
        start_line_nxt   = sl;
        start_column_nxt = sc;
        if (cr || (lf && !prev_cr_r)) begin
          if (!(&line_r)) begin
            line_nxt = line_r + LINE_BITS'(1);
          end
          column_nxt = '0;
        end else if (have_pending_r && !(cr || lf || prev_cr_r || prev_lf_r)) begin
          if (!(&column_r)) begin
            column_nxt = column_r + COLUMN_BITS'(1);
          end
        end
        prev_cr_nxt = cr;
        prev_lf_nxt = lf;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lex_state_r    <= dtl_pkg::ST_SCAN;
      have_pending_r <= 1'b0;
      token_open_r   <= 1'b0;
      line_r         <= '0;
      column_r       <= '0;
      prev_cr_r      <= 1'b0;
      prev_lf_r      <= 1'b0;
    end else begin
      lex_state_r    <= lex_state_nxt;
      have_pending_r <= have_pending_nxt;
      token_open_r   <= token_open_nxt;
      line_r         <= line_nxt;
      column_r       <= column_nxt;
      prev_cr_r      <= prev_cr_nxt;
      prev_lf_r      <= prev_lf_nxt;
    end
  end

  always_ff @(posedge clk) begin
    pending_r      <= pending_nxt;
    start_line_r   <= start_line_nxt;
    start_column_r <= start_column_nxt;
  end

endmodule

`default_nettype wire

// ===== sv/dtl_queue.sv =====
// dtl_queue: short result queue, two pushes and one pop per cycle.
// Depends on dtl_pkg.
`default_nettype none

module dtl_queue #(
  parameter int W = 16
) (
  input  wire logic         clk,
  input  wire logic         rst_n,
  input  wire dtl_pkg::q_push_t q_push,
  input  wire logic [W-1:0] q_data0,
  input  wire logic [W-1:0] q_data1,
  input  wire logic         pop,
  output dtl_pkg::q_stat_t  q_stat,
  output logic [W-1:0]      head
);

  localparam int DEPTH = dtl_pkg::QUEUE_DEPTH;
  localparam int PTR_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);

  logic [W-1:0]     mem [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt, rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r + PTR_W'(q_push.push0) + PTR_W'(q_push.push1);
    rd_ptr_nxt = rd_ptr_r + PTR_W'(pop);
    count_nxt  = count_r + CNT_W'(q_push.push0) + CNT_W'(q_push.push1) - CNT_W'(pop);
  end

  assign q_stat.room     = (count_r <= CNT_W'(DEPTH - 2));
  assign q_stat.nonempty = (count_r != '0);
  assign head            = mem[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (q_push.push0) begin
      mem[wr_ptr_r] <= q_data0;
    end
    if (q_push.push1) begin
      mem[wr_ptr_r + PTR_W'(1)] <= q_data1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

endmodule

`default_nettype wire

// ===== sv/dtl_back.sv =====
// dtl_back: output register that drains the result queue onto the out channel.
// Depends on dtl_pkg and dtl_if.
`default_nettype none

module dtl_back #(
  parameter int LINE_BITS   = dtl_pkg::LINE_BITS_DEF,
  parameter int COLUMN_BITS = dtl_pkg::COLUMN_BITS_DEF,
  parameter int ENTRY_W     = $bits(dtl_pkg::res_base_t) + LINE_BITS + COLUMN_BITS
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire dtl_pkg::q_stat_t   q_stat,
  input  wire logic [ENTRY_W-1:0] head,
  output logic                    pop,
  dtl_out_if.source               out_ch
);

  localparam int BASE_W = $bits(dtl_pkg::res_base_t);

  logic               out_valid_r;
  logic [ENTRY_W-1:0] entry_r;
  dtl_pkg::res_base_t base;

  assign pop  = q_stat.nonempty && (!out_valid_r || out_ch.ready);
  assign base = dtl_pkg::res_base_t'(entry_r[ENTRY_W-1 -: BASE_W]);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (pop) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      entry_r <= head;
    end
  end

  assign out_ch.valid        = out_valid_r;
  assign out_ch.char_out     = base.char_out;
  assign out_ch.has_char     = base.has_char;
  assign out_ch.token_kind   = base.token_kind;
  assign out_ch.token_end    = base.token_end;
  assign out_ch.eof_status   = base.eof_status;
  assign out_ch.last_result  = base.last_result;
  assign out_ch.token_line   = entry_r[COLUMN_BITS +: LINE_BITS];
  assign out_ch.token_column = entry_r[COLUMN_BITS-1:0];

endmodule

`default_nettype wire

// ===== sv/delimited_text_token_lexer_top.sv =====
// Delimited text token lexer, top level: configuration registers, lexer
// front, result queue and output register. Depends on dtl_pkg, dtl_if,
// dtl_front, dtl_queue and dtl_back.
// Path: a result reaches out_ch from the word causing it through the queue
// write and then the output register. Throughput: one word per cycle while
// in_ch.ready is high; an end-of-input word gives up to two results, drained
// by the output register one per cycle while out_ch.ready is high; in_ch.ready
// falls while the four-entry queue has fewer than two free entries.
// Reset (rst_n, synchronous): lexer state, positions and queue cleared,
// configuration registers back to their defaults.
`default_nettype none

module delimited_text_token_lexer_top #(
  parameter int LINE_BITS   = dtl_pkg::LINE_BITS_DEF,
  parameter int COLUMN_BITS = dtl_pkg::COLUMN_BITS_DEF
) (
  input  wire logic                                 clk,
  input  wire logic                                 rst_n,
  dtl_in_if.sink                                    in_ch,
  dtl_out_if.source                                 out_ch,
  input  wire logic                                 cfg_we,
  input  wire logic [dtl_pkg::CFG_IDX_BITS-1:0]     cfg_index,
  input  wire logic [dtl_pkg::CFG_DATA_BITS-1:0]    cfg_wdata
);

  localparam int ENTRY_W = $bits(dtl_pkg::res_base_t) + LINE_BITS + COLUMN_BITS;

  dtl_pkg::cfg_t     cfg_r;
  dtl_pkg::q_push_t  q_push;
  dtl_pkg::q_stat_t  q_stat;
  logic [ENTRY_W-1:0] q_data0, q_data1, head;
  logic              pop;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.comment_char       <= dtl_pkg::RST_COMMENT;
      cfg_r.statement_sep_char <= dtl_pkg::RST_STMT_SEP;
      cfg_r.terminator_char    <= dtl_pkg::RST_TERM;
      cfg_r.value_sep_char     <= dtl_pkg::RST_VALUE;
      cfg_r.tuple_sep_char     <= dtl_pkg::RST_TUPLE;
      cfg_r.string_delim_char  <= dtl_pkg::RST_STR;
    end else if (cfg_we) begin
      case (cfg_index)
        dtl_pkg::REG_COMMENT:  cfg_r.comment_char       <= cfg_wdata;
        dtl_pkg::REG_STMT_SEP: cfg_r.statement_sep_char <= cfg_wdata;
        dtl_pkg::REG_TERM:     cfg_r.terminator_char    <= cfg_wdata;
        dtl_pkg::REG_VALUE:    cfg_r.value_sep_char     <= cfg_wdata;
        dtl_pkg::REG_TUPLE:    cfg_r.tuple_sep_char     <= cfg_wdata;
        dtl_pkg::REG_STR:      cfg_r.string_delim_char  <= cfg_wdata;
        default: ;
      endcase
    end
  end

  dtl_front #(
    .LINE_BITS   (LINE_BITS),
    .COLUMN_BITS (COLUMN_BITS),
    .ENTRY_W     (ENTRY_W)
  ) u_front (
    .clk     (clk),
    .rst_n   (rst_n),
    .cfg     (cfg_r),
    .in_ch   (in_ch),
    .q_stat  (q_stat),
    .q_push  (q_push),
    .q_data0 (q_data0),
    .q_data1 (q_data1)
  );

  dtl_queue #(
    .W (ENTRY_W)
  ) u_queue (
    .clk     (clk),
    .rst_n   (rst_n),
    .q_push  (q_push),
    .q_data0 (q_data0),
    .q_data1 (q_data1),
    .pop     (pop),
    .q_stat  (q_stat),
    .head    (head)
  );

  dtl_back #(
    .LINE_BITS   (LINE_BITS),
    .COLUMN_BITS (COLUMN_BITS),
    .ENTRY_W     (ENTRY_W)
  ) u_back (
    .clk    (clk),
    .rst_n  (rst_n),
    .q_stat (q_stat),
    .head   (head),
    .pop    (pop),
    .out_ch (out_ch)
  );

endmodule

`default_nettype wire

// ===== sv/dtl_checker.sv =====
// dtl_checker: port-level checks on the lexer's result channel, bound to
// delimited_text_token_lexer_top. Depends on dtl_pkg.
`default_nettype none

module dtl_checker #(
  parameter int LINE_BITS   = dtl_pkg::LINE_BITS_DEF,
  parameter int COLUMN_BITS = dtl_pkg::COLUMN_BITS_DEF
) (
  input wire logic                   clk,
  input wire logic                   rst_n,
  input wire logic                   out_valid,
  input wire logic                   out_ready,
  input wire logic [7:0]             char_out,
  input wire logic                   has_char,
  input wire logic [2:0]             token_kind,
  input wire logic                   token_end,
  input wire logic [1:0]             eof_status,
  input wire logic [LINE_BITS-1:0]   token_line,
  input wire logic [COLUMN_BITS-1:0] token_column,
  input wire logic                   last_result
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid &&
      $stable({char_out, has_char, token_kind, token_end, eof_status,
               token_line, token_column, last_result}))
    else $error("result word changed while stalled");

  a_eof_shape: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (eof_status != dtl_pkg::EOF_NONE) |->
      !has_char && !token_end && last_result && (token_kind == dtl_pkg::KIND_INVALID))
    else $error("malformed end-of-input word");

  a_char_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !has_char |-> (char_out == 8'h00))
    else $error("char_out set without has_char");

  a_quiet_end: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !has_char && (eof_status == dtl_pkg::EOF_NONE) |-> token_end)
    else $error("byteless word that does not close a token");

endmodule

bind delimited_text_token_lexer_top dtl_checker #(
  .LINE_BITS   (LINE_BITS),
  .COLUMN_BITS (COLUMN_BITS)
) u_dtl_checker (
  .clk          (clk),
  .rst_n        (rst_n),
  .out_valid    (out_ch.valid),
  .out_ready    (out_ch.ready),
  .char_out     (out_ch.char_out),
  .has_char     (out_ch.has_char),
  .token_kind   (out_ch.token_kind),
  .token_end    (out_ch.token_end),
  .eof_status   (out_ch.eof_status),
  .token_line   (out_ch.token_line),
  .token_column (out_ch.token_column),
  .last_result  (out_ch.last_result)
);

`default_nettype wire

// ===== test/tb_delimited_text_token_lexer_top.sv =====
// Self-checking bench for delimited_text_token_lexer_top: drives text words and
// register writes, predicts every token result and compares them in order.
// Depends on dtl_pkg, dtl_if and the lexer top level.
module tb_delimited_text_token_lexer_top;
  timeunit 1ns;
  timeprecision 1ps;

  import dtl_pkg::*;

  localparam int LB = LINE_BITS_DEF;
  localparam int CB = COLUMN_BITS_DEF;
  localparam logic [CFG_IDX_BITS-1:0] REG_ORDER [6] =
    '{REG_COMMENT, REG_STMT_SEP, REG_TERM, REG_VALUE, REG_TUPLE, REG_STR};

  typedef struct {
    logic [7:0]    char_out;
    logic          has_char;
    logic [2:0]    token_kind;
    logic          token_end;
    logic [1:0]    eof_status;
    logic [LB-1:0] token_line;
    logic [CB-1:0] token_column;
    logic          last_result;
  } token_result_t;

  class token_scoreboard;
    token_result_t expected_tokens[$];
    int errors;
    int results_seen;
    logic [7:0] comment_ch, ssep_ch, term_ch, value_ch, tuple_ch, delim_ch;
    lex_state_t lex_st;
    logic [7:0] pend_byte;
    bit have_pend, tok_open, prev_cr, prev_lf;
    logic [LB-1:0] line_cnt, tok_line;
    logic [CB-1:0] col_cnt, tok_col;

    function new();
      comment_ch = RST_COMMENT;
      ssep_ch    = RST_STMT_SEP;
      term_ch    = RST_TERM;
      value_ch   = RST_VALUE;
      tuple_ch   = RST_TUPLE;
      delim_ch   = RST_STR;
      errors = 0;
      results_seen = 0;
      clear_lexer();
    endfunction

    function void clear_lexer();
      lex_st = ST_SCAN;
      pend_byte = 8'h00;
      have_pend = 1'b0;
      tok_open = 1'b0;
      prev_cr = 1'b0;
      prev_lf = 1'b0;
      line_cnt = '0;
      col_cnt = '0;
      tok_line = '0;
      tok_col = '0;
    endfunction

    function void set_reg(logic [CFG_IDX_BITS-1:0] idx, logic [7:0] val);
      case (idx)
        REG_COMMENT:  comment_ch = val;
        REG_STMT_SEP: ssep_ch = val;
        REG_TERM:     term_ch = val;
        REG_VALUE:    value_ch = val;
        REG_TUPLE:    tuple_ch = val;
        REG_STR:      delim_ch = val;
        default: ;
      endcase
    endfunction

    function lex_state_t step_state(lex_state_t cur, logic [7:0] c);
      bit nl, ws, alpha, digit;
      nl = (c == CHAR_LF) || (c == CHAR_CR);
      ws = nl || (c == CHAR_SPACE) || (c == CHAR_TAB);
      alpha = (c >= CHAR_UPPER_A && c <= CHAR_UPPER_Z) ||
              (c >= CHAR_LOWER_A && c <= CHAR_LOWER_Z) || (c == CHAR_USCORE);
      digit = (c >= CHAR_ZERO && c <= CHAR_NINE) ||
              (c == CHAR_MINUS && cur != ST_NUMBER && cur != ST_WORD);
      if (cur == ST_STR_START || cur == ST_STR)
        return (c == delim_ch || nl) ? ST_STR_END : ST_STR;
      if ((cur == ST_COMMENT && !nl) || c == comment_ch) return ST_COMMENT;
      if (ws) return ST_SCAN;
      if (alpha) return ST_WORD;
      if (digit) return ST_NUMBER;
      if (c == value_ch) return ST_VALUE;
      if (c == tuple_ch) return ST_TUPLE;
      if (c == ssep_ch) return ST_SSEP;
      if (c == term_ch) return ST_TERM;
      if (c == delim_ch) return ST_STR_START;
      return ST_INVALID;
    endfunction

    function bit keeps_byte(lex_state_t s);
      case (s)
        ST_INVALID, ST_WORD, ST_NUMBER, ST_STR,
        ST_VALUE, ST_TUPLE, ST_SSEP, ST_TERM: return 1'b1;
        default: return 1'b0;
      endcase
    endfunction

    function bit closes_token(lex_state_t cur, lex_state_t nxt);
      case (cur)
        ST_WORD, ST_NUMBER, ST_STR_END: return cur != nxt;
        ST_INVALID, ST_VALUE, ST_TUPLE, ST_SSEP, ST_TERM: return 1'b1;
        default: return 1'b0;
      endcase
    endfunction

    function logic [2:0] kind_code(lex_state_t s);
      case (s)
        ST_WORD:                          return KIND_WORD;
        ST_NUMBER:                        return KIND_NUMBER;
        ST_STR_START, ST_STR, ST_STR_END: return KIND_STRING;
        ST_VALUE:                         return KIND_VALUE;
        ST_TUPLE:                         return KIND_TUPLE;
        ST_SSEP:                          return KIND_SSEP;
        ST_TERM:                          return KIND_TERM;
        default:                          return KIND_INVALID;
      endcase
    endfunction

    function void push_token(logic [7:0] ch, logic has, logic [2:0] kind, logic tend,
                             logic [1:0] eof, logic [LB-1:0] ln, logic [CB-1:0] col);
      token_result_t t;
      t.char_out = ch;
      t.has_char = has;
      t.token_kind = kind;
      t.token_end = tend;
      t.eof_status = eof;
      t.token_line = ln;
      t.token_column = col;
      t.last_result = 1'b0;
      expected_tokens.push_back(t);
    endfunction

    // CR-LF counts as one line break; the word after a break stays at column 0
    function void bump_position(logic [7:0] b);
      bit cr, lf;
      cr = (b == CHAR_CR);
      lf = (b == CHAR_LF);
      if (cr || (lf && !prev_cr)) begin
        if (line_cnt != '1) line_cnt++;
        col_cnt = '0;
      end else if (have_pend && !(cr || lf || prev_cr || prev_lf)) begin
        if (col_cnt != '1) col_cnt++;
      end
      prev_cr = cr;
      prev_lf = lf;
    endfunction

    function void consume_pending(logic [7:0] b);
      lex_state_t nxt;
      bit keep, done;
      if (!tok_open && lex_st != ST_SCAN && lex_st != ST_COMMENT) begin
        tok_line = line_cnt;
        tok_col = col_cnt;
        tok_open = 1'b1;
      end
      nxt = step_state(lex_st, b);
      keep = keeps_byte(lex_st);
      done = closes_token(lex_st, nxt);
      if (keep || done)
        push_token(keep ? pend_byte : 8'h00, keep, kind_code(lex_st), done, EOF_NONE,
                   tok_line, tok_col);
      if (done) tok_open = 1'b0;
      lex_st = nxt;
    endfunction

    function void predict_word(logic [7:0] b, logic eoi);
      int n_prior;
      n_prior = expected_tokens.size();
      if (!eoi) begin
        if (!have_pend) begin
          bump_position(b);
          lex_st = step_state(ST_SCAN, b);
        end else begin
          consume_pending(b);
          bump_position(b);
        end
        pend_byte = b;
        have_pend = 1'b1;
      end else begin
        if (have_pend) consume_pending(CHAR_LF);
        if (tok_open)
          push_token(8'h00, 1'b0, KIND_INVALID, 1'b0, EOF_OPEN, tok_line, tok_col);
        else
          push_token(8'h00, 1'b0, KIND_INVALID, 1'b0, EOF_CLEAN, line_cnt, col_cnt);
        clear_lexer();
      end
      if (expected_tokens.size() > n_prior)
        expected_tokens[expected_tokens.size()-1].last_result = 1'b1;
    endfunction

    task report(string msg);
      if (errors < 100) $display("[%0t] mismatch: %s", $realtime, msg);
      errors++;
    endtask

    task check_field(string name, logic [31:0] got_v, logic [31:0] exp_v);
      if (got_v !== exp_v)
        report($sformatf("result %0d %s got %0h expected %0h", results_seen, name,
                         got_v, exp_v));
    endtask

    task compare_token(token_result_t got);
      token_result_t exp;
      results_seen++;
      if (expected_tokens.size() == 0) begin
        report($sformatf("result %0d arrived with nothing expected (char %0h eof %0d)",
                         results_seen, got.char_out, got.eof_status));
        return;
      end
      exp = expected_tokens.pop_front();
      check_field("char_out", 32'(got.char_out), 32'(exp.char_out));
      check_field("has_char", 32'(got.has_char), 32'(exp.has_char));
      check_field("token_kind", 32'(got.token_kind), 32'(exp.token_kind));
      check_field("token_end", 32'(got.token_end), 32'(exp.token_end));
      check_field("eof_status", 32'(got.eof_status), 32'(exp.eof_status));
      check_field("token_line", 32'(got.token_line), 32'(exp.token_line));
      check_field("token_column", 32'(got.token_column), 32'(exp.token_column));
      check_field("last_result", 32'(got.last_result), 32'(exp.last_result));
    endtask
  endclass

  logic clk;
  logic rst_n;
  logic cfg_we;
  logic [CFG_IDX_BITS-1:0] cfg_index;
  logic [CFG_DATA_BITS-1:0] cfg_wdata;

  dtl_in_if  in_ch ();
  dtl_out_if out_ch ();

  delimited_text_token_lexer_top uut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .out_ch    (out_ch),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  token_scoreboard sb;
  token_result_t observed;
  bit src_idle_en;
  bit sink_idle_en;
  bit hold_req;
  int words_sent;
  int settings_used;

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  initial begin
    #20_000_000;
    $display("timeout with %0d results outstanding", sb.expected_tokens.size());
    $display("RESULT: ERROR");
    $finish;
  end

  // result side: random stalls, plus a long hold-off on request
  initial begin
    int stall_left;
    int hold_left;
    stall_left = 0;
    hold_left = 0;
    out_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_req) begin
        hold_left = 80;
        hold_req = 1'b0;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ch.ready <= 1'b0;
      end else if (stall_left > 0) begin
        stall_left--;
        out_ch.ready <= 1'b0;
      end else if (sink_idle_en && $urandom_range(0, 5) == 0) begin
        stall_left = $urandom_range(0, 6);
        out_ch.ready <= 1'b0;
      end else begin
        out_ch.ready <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_ch.valid && out_ch.ready) begin
      observed.char_out = out_ch.char_out;
      observed.has_char = out_ch.has_char;
      observed.token_kind = out_ch.token_kind;
      observed.token_end = out_ch.token_end;
      observed.eof_status = out_ch.eof_status;
      observed.token_line = out_ch.token_line;
      observed.token_column = out_ch.token_column;
      observed.last_result = out_ch.last_result;
      sb.compare_token(observed);
    end
  end

  task automatic send_word(input logic [7:0] b, input logic eoi);
    if (src_idle_en && $urandom_range(0, 4) == 0) begin
      in_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 7)) @(posedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.in_byte <= b;
    in_ch.end_of_input <= eoi;
    do @(posedge clk); while (!in_ch.ready);
    sb.predict_word(b, eoi);
    words_sent++;
  endtask

  task automatic send_text(input string s);
    int i;
    for (i = 0; i < s.len(); i++) send_word(s[i], 1'b0);
  endtask

  function automatic logic [7:0] pick_text_byte();
    case ($urandom_range(0, 19))
      0, 1, 2: return 8'($urandom_range(CHAR_LOWER_A, CHAR_LOWER_Z));
      3:       return 8'($urandom_range(CHAR_UPPER_A, CHAR_UPPER_Z));
      4:       return CHAR_USCORE;
      5, 6:    return 8'($urandom_range(CHAR_ZERO, CHAR_NINE));
      7:       return CHAR_MINUS;
      8:       return $urandom_range(0, 1) ? CHAR_SPACE : CHAR_TAB;
      9:       return $urandom_range(0, 1) ? CHAR_CR : CHAR_LF;
      10:      return sb.value_ch;
      11:      return sb.tuple_ch;
      12:      return sb.ssep_ch;
      13:      return sb.term_ch;
      14:      return sb.comment_ch;
      15:      return sb.delim_ch;
      default: return 8'($urandom);
    endcase
  endfunction

  // mostly token-shaped text, with strings (some left open), stray bytes and end-of-input words
  task automatic random_text(input int n);
    int k;
    int len;
    int j;
    k = 0;
    while (k < n) begin
      case ($urandom_range(0, 19))
        0: begin
          send_word(8'($urandom), 1'b1);
          k++;
        end
        1, 2: begin
          send_word(sb.delim_ch, 1'b0);
          len = $urandom_range(0, 5);
          for (j = 0; j < len; j++)
            send_word($urandom_range(0, 3) == 0 ? 8'($urandom) : pick_text_byte(), 1'b0);
          k += len + 1;
          if ($urandom_range(0, 3) != 0) begin
            send_word(sb.delim_ch, 1'b0);
            k++;
          end
        end
        default: begin
          send_word(pick_text_byte(), 1'b0);
          k++;
        end
      endcase
    end
  endtask

  task automatic settle();
    in_ch.valid <= 1'b0;
    while (sb.expected_tokens.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic program_regs(input logic [7:0] vals [6]);
    int i;
    for (i = 0; i < 6; i++) begin
      cfg_we <= 1'b1;
      cfg_index <= REG_ORDER[i];
      cfg_wdata <= vals[i];
      @(posedge clk);
      sb.set_reg(REG_ORDER[i], vals[i]);
    end
    cfg_we <= 1'b0;
    settings_used++;
  endtask

  initial begin
    logic [7:0] rnd_vals [6];
    int p;
    sb = new();
    words_sent = 0;
    settings_used = 1;
    src_idle_en = 1'b1;
    sink_idle_en = 1'b1;
    hold_req = 1'b0;
    rst_n <= 1'b0;
    cfg_we <= 1'b0;
    cfg_index <= '0;
    cfg_wdata <= '0;
    in_ch.valid <= 1'b0;
    in_ch.in_byte <= 8'h00;
    in_ch.end_of_input <= 1'b0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;

    // empty stream, every token kind, comment, CR-LF, extreme bytes, open string at end
    send_word(8'h00, 1'b1);
    send_text("a=-1/b2,_z;|x|#c\r\n");
    send_word(8'h00, 1'b0);
    send_word(8'hFF, 1'b0);
    send_text("\t|q");
    send_word(8'hFF, 1'b1);
    settle();

    program_regs('{8'h00, 8'hFF, 8'h80, 8'h7F, 8'h01, 8'hFE});
    random_text(300);
    send_word(8'($urandom), 1'b1);
    settle();

    program_regs('{8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF});
    random_text(200);
    send_word(8'($urandom), 1'b1);
    settle();

    // separators that collide with letters, digits, minus and white space
    program_regs('{8'h71, 8'h37, CHAR_SPACE, CHAR_MINUS, CHAR_LF, 8'h22});
    random_text(250);
    send_word(8'($urandom), 1'b1);
    settle();

    for (p = 0; p < 2; p++) begin
      foreach (rnd_vals[j]) rnd_vals[j] = 8'($urandom);
      program_regs(rnd_vals);
      if (p == 0) hold_req = 1'b1;
      random_text(300);
      send_word(8'($urandom), 1'b1);
      settle();
    end

    src_idle_en = 1'b0;
    sink_idle_en = 1'b0;
    program_regs('{RST_COMMENT, RST_STMT_SEP, RST_TERM, RST_VALUE, RST_TUPLE, RST_STR});
    random_text(500);
    send_word(8'($urandom), 1'b1);
    settle();
    repeat (10) @(posedge clk);

    $display("Sent %0d text words under %0d register settings; %0d token results checked.",
             words_sent, settings_used, sb.results_seen);
    $display("Covered an empty stream, open strings at end of input, colliding separators"
             , " and a long result stall.");
    if (sb.errors == 0 && sb.expected_tokens.size() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("%0d mismatches", sb.errors);
      $display("RESULT: ERROR");
    end
    $finish;
  end
endmodule
